### rtl/ccs_pkg.sv
// Shared types and constants for the C comment stripper.
`timescale 1ns / 1ps
`default_nettype none

package ccs_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    // Scanner mode, one-hot.
    typedef enum logic [3:0] {
        MODE_TEXT  = 4'b0001,
        MODE_HELD  = 4'b0010,
        MODE_LINE  = 4'b0100,
        MODE_BLOCK = 4'b1000
    } mode_t;

    // One output beat.
    typedef struct packed {
        logic [7:0] out_ch;
        logic       is_newline;
        logic       last;
    } res_t;

    // Number of beats produced by one input item (0..2).
    typedef logic [1:0] cnt_t;

endpackage

`default_nettype wire

### rtl/ccs_core.sv
// Comment scanner: mode state and per-item result generation.
`timescale 1ns / 1ps
`default_nettype none

module ccs_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic         is_eol,
    input  wire logic [7:0]   ch,
    output ccs_pkg::cnt_t     res_cnt,
    output ccs_pkg::res_t     res0,
    output ccs_pkg::res_t     res1
);
    import ccs_pkg::*;

    mode_t mode_reg, mode_next;
    logic  skip_reg, skip_next;
    logic  star_reg, star_next;
    logic  has_reg, has_next;

    always_comb
    begin
        logic  is_slash;
        logic  is_star;
        cnt_t  n;
        res_t  r0;
        res_t  r1;

        is_slash  = (ch == CH_SLASH);
        is_star   = (ch == CH_STAR);
        n         = '0;
        r0        = '0;
        r1        = '0;
        mode_next = mode_reg;
        skip_next = skip_reg;
        star_next = star_reg;
        has_next  = has_reg;

        if (is_eol)
        begin
            if (mode_reg == MODE_HELD)
            begin
                r0.out_ch = CH_SLASH;
                n         = 2'd1;
                has_next  = 1'b1;
                mode_next = MODE_TEXT;
            end
            else if (mode_reg == MODE_LINE)
            begin
                mode_next = MODE_TEXT;
            end
            // newline only outside a block comment and on a non-empty line
            if (mode_next != MODE_BLOCK && has_next)
            begin
                if (n == 2'd0)
                begin
                    r0.is_newline = 1'b1;
                end
                else
                begin
                    r1.is_newline = 1'b1;
                end
                n        = n + 2'd1;
                has_next = 1'b0;
            end
            skip_next = 1'b0;
            star_next = 1'b0;
        end
        else
        begin
            case (mode_reg)
                MODE_TEXT:
                begin
                    if (is_slash)
                    begin
                        mode_next = MODE_HELD;
                    end
                    else
                    begin
                        r0.out_ch = ch;
                        n         = 2'd1;
                        has_next  = 1'b1;
                    end
                end
                MODE_HELD:
                begin
                    if (is_slash)
                    begin
                        mode_next = MODE_LINE;
                    end
                    else if (is_star)
                    begin
                        mode_next = MODE_BLOCK;
                        skip_next = 1'b1;
                    end
                    else
                    begin
                        r0.out_ch = CH_SLASH;
                        r1.out_ch = ch;
                        n         = 2'd2;
                        has_next  = 1'b1;
                        mode_next = MODE_TEXT;
                    end
                end
                MODE_LINE:
                begin
                end
                MODE_BLOCK:
                begin
                    if (skip_reg)
                    begin
                        skip_next = 1'b0;
                    end
                    else if (is_slash && star_reg)
                    begin
                        mode_next = MODE_TEXT;
                    end
                end
                default:
                begin
                    mode_next = MODE_TEXT;
                end
            endcase
            star_next = is_star;
        end

        r0.last = (n == 2'd1);
        r1.last = 1'b1;
        res_cnt = n;
        res0    = r0;
        res1    = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_TEXT;
            skip_reg <= 1'b0;
            star_reg <= 1'b0;
            has_reg  <= 1'b0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            skip_reg <= skip_next;
            star_reg <= star_next;
            has_reg  <= has_next;
        end
    end

endmodule

`default_nettype wire

### rtl/ccs_obuf.sv
// Two-entry output buffer that takes up to two beats per item.
`timescale 1ns / 1ps
`default_nettype none

module ccs_obuf (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  ccs_pkg::cnt_t     push_cnt,
    input  ccs_pkg::res_t     push0,
    input  ccs_pkg::res_t     push1,
    output logic              space,
    output logic              out_valid,
    input  wire logic         out_ready,
    output ccs_pkg::res_t     head,
    output ccs_pkg::cnt_t     level
);
    import ccs_pkg::*;

    res_t slot0_reg, slot0_next;
    res_t slot1_reg, slot1_next;
    cnt_t cnt_reg, cnt_next;
    logic pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    // room for a full pair once this cycle's pop is counted
    assign space     = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);
    assign head      = slot0_reg;
    assign level     = cnt_reg;

    always_comb
    begin
        slot0_next = pop ? slot1_reg : slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg - {1'b0, pop};
        if (push)
        begin
            // buffer is empty after the pop whenever push is allowed
            slot0_next = push0;
            slot1_next = push1;
            cnt_next   = push_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

### rtl/c_comment_stripper.sv
// An input beat passes the input register and then the result buffer to reach the output.
// Throughput: one input item per cycle while out_ready is high and items produce at most
// one beat each; an item producing two beats holds the input until its second beat is taken.
// The two-entry result buffer sets the rate; the scanner itself has no loop.
// Reset (rst_n, async, active low) empties both stages and returns to plain text mode.
`timescale 1ns / 1ps
`default_nettype none

module c_comment_stripper (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       is_eol,
    input  wire logic [7:0] ch,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_ch,
    output logic            is_newline,
    output logic            last
);
    import ccs_pkg::*;

    logic       iv_reg;
    logic       eol_reg;
    logic [7:0] ch_reg;
    logic       move;
    logic       space;
    cnt_t       res_cnt;
    cnt_t       level;
    res_t       res0;
    res_t       res1;
    res_t       head;

    assign move     = iv_reg && space;
    assign in_ready = !iv_reg || move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            iv_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            eol_reg <= is_eol;
            ch_reg  <= ch;
        end
    end

    ccs_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (move),
        .is_eol  (eol_reg),
        .ch      (ch_reg),
        .res_cnt (res_cnt),
        .res0    (res0),
        .res1    (res1)
    );

    ccs_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (move),
        .push_cnt  (res_cnt),
        .push0     (res0),
        .push1     (res1),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head),
        .level     (level)
    );

    assign out_ch     = head.out_ch;
    assign is_newline = head.is_newline;
    assign last       = head.last;

    a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
        level != 2'd3)
        else $error("output buffer overfilled");

    a_nl_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_newline |-> out_ch == 8'd0 && last)
        else $error("newline beat carries a character or is not last");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && last)
        else $error("first beat of a pair not followed by its last beat");

    a_move_room: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> level == $past(res_cnt))
        else $error("buffer level does not match pushed beat count");

endmodule

`default_nettype wire
